// ===== rtl/ght_pkg.sv =====
// ght_pkg: shared types and constants of the generational handle table
`default_nettype none

package ght_pkg;

    // field widths
    localparam int KIND_W     = 16;
    localparam int GEN_W      = 32;
    localparam int HANDLE_W   = 64;
    localparam int OP_W       = 2;
    localparam int SLOT_OUT_W = 8;
    localparam int SLOT_W     = KIND_W + GEN_W;

    // operation codes (code 3 has no meaning and is refused)
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_LOOKUP  = 2'd1,
        OP_RELEASE = 2'd2
    } t_op;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic exec;
    } t_ctrl_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_last;
        logic out_blocked;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/ght_ram.sv =====
// ght_ram: generic single-write, single-read RAM with registered read data
`default_nettype none

module ght_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/ght_ctrl.sv =====
// ght_ctrl: sequencing state machine of the generational handle table
`default_nettype none

module ght_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output      logic                o_in_ready,
    input  wire ght_pkg::t_dp_status i_status,
    output      ght_pkg::t_ctrl_cmd  o_cmd
);

    ght_pkg::t_state r_state;
    ght_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ght_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        case (r_state)
            ght_pkg::S_CLEAR: begin
                o_cmd.clear_en = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ght_pkg::S_IDLE;
                end
            end
            ght_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ght_pkg::S_EXEC;
                end
            end
            ght_pkg::S_EXEC: begin
                // hold while the previous result still sits unread
                if (!i_status.out_blocked) begin
                    o_cmd.exec = 1'b1;
                    n_state    = ght_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ght_pkg::S_CLEAR;
            end
        endcase
    end

    // checks
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ght_pkg::S_CLEAR) |-> !o_in_ready)
        else $error("item taken during clearing pass");
    a_exec_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ght_pkg::S_EXEC))
        else $error("accepted item not executed");
    a_exec_not_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !i_status.out_blocked)
        else $error("execute while result register full");

endmodule

`default_nettype wire

// ===== rtl/ght_datapath.sv =====
// ght_datapath: slot memory, free bitmap, checks and result register
`default_nettype none

module ght_datapath #(
    parameter int CAPACITY = 256
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire ght_pkg::t_ctrl_cmd                 i_cmd,
    output      ght_pkg::t_dp_status                o_status,
    input  wire logic                               i_cfg_valid,
    input  wire logic                               i_cfg_allocation_enabled,
    input  wire logic [ght_pkg::OP_W-1:0]           i_operation,
    input  wire logic [ght_pkg::HANDLE_W-1:0]       i_handle_in,
    input  wire logic [ght_pkg::KIND_W-1:0]         i_kind_code,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      logic [1:0]                         o_status_code,
    output      logic [ght_pkg::HANDLE_W-1:0]       o_handle_out,
    output      logic [ght_pkg::SLOT_OUT_W-1:0]     o_slot_index
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int GEN_W = ght_pkg::GEN_W;
    localparam int KIND_W = ght_pkg::KIND_W;

    // configuration register
    logic r_alloc_en;

    // clearing pass and free bitmap
    logic [IDX_W-1:0]    r_clr_addr;
    logic [CAPACITY-1:0] r_free;
    logic [IDX_W-1:0]    first_free;

    // latched item
    ght_pkg::t_op        r_op;
    logic [1:0]          r_op_raw;
    logic [KIND_W-1:0]   r_kind;
    logic [GEN_W-1:0]    r_gen_in;
    logic                r_lookup_bad;
    logic                r_alloc_bad;
    logic                r_full;
    logic [IDX_W-1:0]    r_addr;

    // item decode at accept
    logic [GEN_W-1:0]    hnd_low;
    logic [GEN_W-1:0]    hnd_low_m1;
    logic [IDX_W-1:0]    n_addr;

    // memory
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [ght_pkg::SLOT_W-1:0] mem_wdata;
    logic [IDX_W-1:0]       mem_raddr;
    logic [ght_pkg::SLOT_W-1:0] mem_rdata;
    logic [GEN_W-1:0]       rd_gen;
    logic [KIND_W-1:0]      rd_kind;
    logic [GEN_W-1:0]       gen_inc;
    logic [GEN_W-1:0]       new_gen;

    // execute results
    ght_pkg::t_status       res_status;
    logic [ght_pkg::HANDLE_W-1:0] res_handle;
    logic [ght_pkg::SLOT_OUT_W-1:0] res_slot;
    logic                   res_take;
    logic                   res_free;
    logic [GEN_W-1:0]       idx_ext;

    // result register
    logic                   r_out_valid;
    ght_pkg::t_status       r_res_status;
    logic [ght_pkg::HANDLE_W-1:0] r_res_handle;
    logic [ght_pkg::SLOT_OUT_W-1:0] r_res_slot;

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_alloc_en <= i_cfg_allocation_enabled;
        end
    end

    // lowest free slot
    always_comb begin
        first_free = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                first_free = IDX_W'(i);
            end
        end
    end

    // handle decode
    assign hnd_low    = i_handle_in[GEN_W-1:0];
    assign hnd_low_m1 = hnd_low - GEN_W'(1);
    assign n_addr     = (ght_pkg::t_op'(i_operation) == ght_pkg::OP_ALLOC) ?
                        first_free : hnd_low_m1[IDX_W-1:0];

    // latch the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op_raw     <= i_operation;
            r_op         <= ght_pkg::t_op'(i_operation);
            r_kind       <= i_kind_code;
            r_gen_in     <= i_handle_in[ght_pkg::HANDLE_W-1:GEN_W];
            r_lookup_bad <= (hnd_low == '0) || (i_kind_code == '0) ||
                            (hnd_low > GEN_W'(CAPACITY));
            r_alloc_bad  <= !r_alloc_en || (i_kind_code == '0);
            r_full       <= (r_free == '0);
            r_addr       <= n_addr;
        end
    end

    // slot word is {generation, kind}
    assign rd_gen  = mem_rdata[KIND_W +: GEN_W];
    assign rd_kind = mem_rdata[KIND_W-1:0];
    assign gen_inc = rd_gen + GEN_W'(1);
    assign new_gen = (gen_inc == '0) ? GEN_W'(1) : gen_inc;
    assign idx_ext = GEN_W'(r_addr);

    // execute the operation on the read slot
    always_comb begin
        res_status = ght_pkg::ST_INVALID;
        res_handle = '0;
        res_slot   = '0;
        res_take   = 1'b0;
        res_free   = 1'b0;
        case (r_op_raw)
            ght_pkg::OP_ALLOC: begin
                if (r_alloc_bad) begin
                    res_status = ght_pkg::ST_INVALID;
                end else if (r_full) begin
                    res_status = ght_pkg::ST_FULL;
                end else begin
                    res_status = ght_pkg::ST_OK;
                    res_handle = {new_gen, idx_ext + GEN_W'(1)};
                    res_slot   = idx_ext[ght_pkg::SLOT_OUT_W-1:0];
                    res_take   = 1'b1;
                end
            end
            ght_pkg::OP_LOOKUP, ght_pkg::OP_RELEASE: begin
                if (r_lookup_bad || (rd_gen != r_gen_in) || (rd_kind != r_kind)) begin
                    res_status = ght_pkg::ST_NOT_FOUND;
                end else begin
                    res_status = ght_pkg::ST_OK;
                    res_slot   = idx_ext[ght_pkg::SLOT_OUT_W-1:0];
                    res_free   = (r_op == ght_pkg::OP_RELEASE);
                end
            end
            default: begin
                res_status = ght_pkg::ST_INVALID;
            end
        endcase
    end

    // memory ports: clearing sweep, then write-back on execute
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {new_gen, r_kind};
        if (i_cmd.clear_en) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.exec && res_take) begin
            mem_we    = 1'b1;
        end else if (i_cmd.exec && res_free) begin
            mem_we    = 1'b1;
            mem_wdata = {rd_gen, KIND_W'(0)};
        end
    end

    assign mem_raddr = i_cmd.accept ? n_addr : r_addr;

    ght_ram #(
        .WIDTH (ght_pkg::SLOT_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // clearing counter and free bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_free     <= '1;
        end else begin
            if (i_cmd.clear_en) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.exec && res_take) begin
                r_free[r_addr] <= 1'b0;
            end else if (i_cmd.exec && res_free) begin
                r_free[r_addr] <= 1'b1;
            end
        end
    end

    assign o_status.clear_last  = (r_clr_addr == IDX_W'(CAPACITY - 1));
    assign o_status.out_blocked = r_out_valid && !i_out_ready;

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= res_status;
            r_res_handle <= res_handle;
            r_res_slot   <= res_slot;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status_code = r_res_status;
    assign o_handle_out  = r_res_handle;
    assign o_slot_index  = r_res_slot;

    // checks
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("executed item left no result");
    a_alloc_marks_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && res_take) |=> !r_free[$past(r_addr)])
        else $error("allocated slot still marked free");
    a_release_marks_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && res_free) |=> r_free[$past(r_addr)])
        else $error("released slot not marked free");
    a_failure_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res_status != ght_pkg::ST_OK)) |->
        ((r_res_handle == '0) && (r_res_slot == '0)))
        else $error("failed item carries handle or index");

endmodule

`default_nettype wire

// ===== rtl/generational_handle_table_top.sv =====
// generational_handle_table_top: top level of the generational handle table
//
//  channel   direction  handshake                    payload
//  in        in         i_in_valid / o_in_ready      i_operation, i_handle_in, i_kind_code
//  out       out        o_out_valid / i_out_ready    o_status, o_handle_out, o_slot_index
//  cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_allocation_enabled
//
//  an item is accepted in idle, which issues the slot memory read; the execute
//  state then checks the slot and writes it back through the single write port
//  the lowest free slot comes from a priority encoder over the free bitmap
//  after reset a clearing pass over every slot zeroes the slot memory;
//  no item is taken then, configuration writes always are
//  an item whose result finds the output register still full waits there
`default_nettype none

module generational_handle_table_top #(
    parameter int CAPACITY = 256
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [ght_pkg::OP_W-1:0]       i_operation,
    input  wire logic [ght_pkg::HANDLE_W-1:0]   i_handle_in,
    input  wire logic [ght_pkg::KIND_W-1:0]     i_kind_code,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic [1:0]                     o_status,
    output      logic [ght_pkg::HANDLE_W-1:0]   o_handle_out,
    output      logic [ght_pkg::SLOT_OUT_W-1:0] o_slot_index,
    input  wire logic                           i_cfg_valid,
    output      logic                           o_cfg_ready,
    input  wire logic                           i_cfg_allocation_enabled
);

    ght_pkg::t_ctrl_cmd  cmd;
    ght_pkg::t_dp_status dp_status;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;

    // sequencing
    ght_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    // slot storage and result logic
    ght_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cmd                    (cmd),
        .o_status                 (dp_status),
        .i_cfg_valid              (i_cfg_valid),
        .i_cfg_allocation_enabled (i_cfg_allocation_enabled),
        .i_operation              (i_operation),
        .i_handle_in              (i_handle_in),
        .i_kind_code              (i_kind_code),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_status_code            (o_status),
        .o_handle_out             (o_handle_out),
        .o_slot_index             (o_slot_index)
    );

endmodule

`default_nettype wire

// ===== sim/generational_handle_table_top_test.sv =====
// generational_handle_table_top_test: self-checking testbench of the generational handle table
module generational_handle_table_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ght_pkg::*;

    localparam int SLOTS = 256;
    localparam int STALL_LIMIT = 4000;
    localparam int MAX_REPORTS = 100;
    // operation code with no meaning, refused by the block
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_status                status;
        logic [HANDLE_W-1:0]    handle;
        logic [SLOT_OUT_W-1:0]  slot;
    } t_outcome;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind              what;
        logic [OP_W-1:0]        op;
        logic [HANDLE_W-1:0]    handle;
        logic [KIND_W-1:0]      kind;
        logic                   enable;
        bit                     typed;
        t_outcome               want;
    } t_row;

    // dut ports
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [OP_W-1:0]        i_operation;
    logic [HANDLE_W-1:0]    i_handle_in;
    logic [KIND_W-1:0]      i_kind_code;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [1:0]             o_status;
    logic [HANDLE_W-1:0]    o_handle_out;
    logic [SLOT_OUT_W-1:0]  o_slot_index;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_allocation_enabled;

    // own copy of the slot table and the enable register
    logic [KIND_W-1:0]      slot_kind_copy [SLOTS];
    logic [GEN_W-1:0]       slot_gen_copy [SLOTS];
    bit                     alloc_enabled;

    t_outcome               pending_results [$];
    t_row                   directed_plan [$];
    int                     errors = 0;
    int                     stalled_cycles = 0;
    int                     cycle_no = 0;
    wire                    steady = (cycle_no >= 1500 && cycle_no < 3000);

    generational_handle_table_top #(
        .CAPACITY (SLOTS)
    ) dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_in_valid               (i_in_valid),
        .o_in_ready               (o_in_ready),
        .i_operation              (i_operation),
        .i_handle_in              (i_handle_in),
        .i_kind_code              (i_kind_code),
        .o_out_valid              (o_out_valid),
        .i_out_ready              (i_out_ready),
        .o_status                 (o_status),
        .o_handle_out             (o_handle_out),
        .o_slot_index             (o_slot_index),
        .i_cfg_valid              (i_cfg_valid),
        .o_cfg_ready              (o_cfg_ready),
        .i_cfg_allocation_enabled (i_cfg_allocation_enabled)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // slot map behaviour: returns the outcome of one item and updates the table copy
    function automatic t_outcome slot_map_apply(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                                logic [KIND_W-1:0] k);
        t_outcome         r;
        logic [GEN_W-1:0] g;
        logic [31:0]      low;
        int               idx;
        r = '{status: ST_INVALID, handle: '0, slot: '0};
        case (op)
            OP_ALLOC: begin
                if (alloc_enabled && k != '0) begin
                    r.status = ST_FULL;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_kind_copy[i] == '0) begin
                            // generation wraps past zero to one
                            g = slot_gen_copy[i] + 1'b1;
                            if (g == '0) g = 1;
                            slot_gen_copy[i] = g;
                            slot_kind_copy[i] = k;
                            r.status = ST_OK;
                            r.handle = {g, 32'(i + 1)};
                            r.slot = SLOT_OUT_W'(i);
                            break;
                        end
                    end
                end
            end
            OP_LOOKUP, OP_RELEASE: begin
                low = h[31:0];
                r.status = ST_NOT_FOUND;
                if (low != '0 && k != '0 && low <= SLOTS) begin
                    idx = int'(low) - 1;
                    if (slot_gen_copy[idx] == h[63:32] && slot_kind_copy[idx] == k) begin
                        r.status = ST_OK;
                        r.slot = SLOT_OUT_W'(idx);
                        if (op == OP_RELEASE) slot_kind_copy[idx] = '0;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // idle cycles ahead of the next item
    function automatic int draw_gap();
        int n;
        n = 0;
        if (!steady) begin
            while (n < 8 && $urandom_range(0, 99) < 18) n++;
        end
        return n;
    endfunction

    // directed table rows
    function automatic void add_item(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                     logic [KIND_W-1:0] k);
        directed_plan.push_back('{what: ROW_ITEM, op: op, handle: h, kind: k, enable: 1'b0,
                                  typed: 1'b0, want: '{status: ST_OK, handle: '0, slot: '0}});
    endfunction

    function automatic void add_check(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                      logic [KIND_W-1:0] k, t_status st,
                                      logic [HANDLE_W-1:0] hout, logic [SLOT_OUT_W-1:0] idx);
        directed_plan.push_back('{what: ROW_ITEM, op: op, handle: h, kind: k, enable: 1'b0,
                                  typed: 1'b1, want: '{status: st, handle: hout, slot: idx}});
    endfunction

    function automatic void add_cfg(logic v);
        directed_plan.push_back('{what: ROW_CFG, op: OP_ALLOC, handle: '0, kind: '0, enable: v,
                                  typed: 1'b0, want: '{status: ST_OK, handle: '0, slot: '0}});
    endfunction

    // drive one item, record its outcome on acceptance, then hold or drop valid
    task automatic send_request(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                logic [KIND_W-1:0] k, bit typed, t_outcome want, bit more);
        t_outcome predicted;
        int       gap;
        i_operation <= op;
        i_handle_in <= h;
        i_kind_code <= k;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = slot_map_apply(op, h, k);
        pending_results.push_back(typed ? want : predicted);
        gap = more ? draw_gap() : 0;
        if (!more || gap > 0) i_in_valid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    // register write once every result is back
    task automatic set_allocation_enable(logic v);
        while (pending_results.size() != 0) @(posedge i_clk);
        i_cfg_allocation_enabled <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        alloc_enabled = v;
        i_cfg_valid <= 1'b0;
    endtask

    // random item: mostly well-formed handles taken from live slots
    task automatic make_item(int w_alloc, int w_access, output logic [OP_W-1:0] op,
                             output logic [HANDLE_W-1:0] h, output logic [KIND_W-1:0] k);
        int roll;
        int start;
        int idx;
        bit found;
        roll = $urandom_range(0, 99);
        h = {$urandom, $urandom};
        k = KIND_W'($urandom_range(1, 65535));
        if (roll < w_alloc) begin
            op = OP_ALLOC;
            if ($urandom_range(0, 19) == 0) k = '0;
        end else if (roll < w_alloc + w_access) begin
            op = ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_RELEASE;
            start = $urandom_range(0, SLOTS - 1);
            found = 1'b0;
            idx = 0;
            for (int i = 0; i < SLOTS && !found; i++) begin
                if (slot_kind_copy[(start + i) % SLOTS] != '0) begin
                    idx = (start + i) % SLOTS;
                    found = 1'b1;
                end
            end
            if (found) begin
                h = {slot_gen_copy[idx], 32'(idx + 1)};
                k = slot_kind_copy[idx];
                case ($urandom_range(0, 9))
                    0: k = k ^ KIND_W'($urandom_range(1, 65535));
                    1: h[63:32] = h[63:32] + (($urandom_range(0, 1) == 0) ? -32'sd1 : 32'sd1);
                    2: h[31:0] = 32'($urandom_range(1, SLOTS));
                    default: ;
                endcase
            end else begin
                h = {32'($urandom_range(0, 3)), 32'($urandom_range(1, SLOTS))};
            end
        end else begin
            // noise: any operation code, any handle, any kind
            op = OP_W'($urandom_range(0, 3));
            k = KIND_W'($urandom);
            case ($urandom_range(0, 5))
                0: h[31:0] = '0;
                1: h[31:0] = 32'(SLOTS);
                2: h[31:0] = 32'(SLOTS + 1);
                3: h[31:0] = '1;
                default: ;
            endcase
        end
    endtask

    // mismatch report
    task automatic flag(string field, logic [HANDLE_W-1:0] want, logic [HANDLE_W-1:0] got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, field, want, got);
    endtask

    // output side: random back-pressure
    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        i_out_ready <= steady || ($urandom_range(0, 99) >= 18);
    end

    // result checker
    always @(posedge i_clk) begin
        t_outcome head;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result status %0d handle 0x%0h slot %0d",
                             $time, o_status, o_handle_out, o_slot_index);
            end else begin
                head = pending_results.pop_front();
                if (o_status !== head.status) flag("status", head.status, o_status);
                if (o_handle_out !== head.handle) flag("handle_out", head.handle, o_handle_out);
                if (o_slot_index !== head.slot) flag("slot_index", head.slot, o_slot_index);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int               ph_enable [4];
        int               ph_count [4];
        int               ph_alloc [4];
        int               ph_access [4];
        logic [OP_W-1:0]  op;
        logic [HANDLE_W-1:0] h;
        logic [KIND_W-1:0] k;
        t_outcome         none;
        bit               more;

        ph_enable = '{1, 0, 1, 1};
        ph_count  = '{450, 200, 500, 700};
        ph_alloc  = '{70, 30, 25, 40};
        ph_access = '{25, 65, 70, 55};
        none = '{status: ST_OK, handle: '0, slot: '0};

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = OP_ALLOC;
        i_handle_in = '0;
        i_kind_code = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_allocation_enabled = 1'b1;
        for (int i = 0; i < SLOTS; i++) begin
            slot_kind_copy[i] = '0;
            slot_gen_copy[i] = '0;
        end
        alloc_enabled = 1'b1;

        // directed part: extremes, every operation, the refused and not-found cases
        add_check(OP_ALLOC, '0, 16'hFFFF, ST_OK, 64'h0000_0001_0000_0001, 8'd0);
        add_check(OP_ALLOC, '1, 16'h0001, ST_OK, 64'h0000_0001_0000_0002, 8'd1);
        add_check(OP_LOOKUP, 64'h0000_0001_0000_0001, 16'hFFFF, ST_OK, '0, 8'd0);
        add_check(OP_LOOKUP, 64'h0000_0001_0000_0001, 16'h0001, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_LOOKUP, 64'h0000_0002_0000_0001, 16'hFFFF, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_LOOKUP, '0, 16'hFFFF, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_LOOKUP, 64'h0000_0001_0000_0002, 16'h0000, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_LOOKUP, 64'(SLOTS + 1), 16'h0001, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_LOOKUP, 64'(SLOTS), 16'h0001, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_LOOKUP, '1, 16'hFFFF, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_RELEASE, 64'h0000_0001_0000_0001, 16'hFFFF, ST_OK, '0, 8'd0);
        add_check(OP_RELEASE, 64'h0000_0001_0000_0001, 16'hFFFF, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_LOOKUP, 64'h0000_0001_0000_0001, 16'hFFFF, ST_NOT_FOUND, '0, 8'd0);
        add_check(OP_ALLOC, 64'hFFFF_FFFF_0000_0000, 16'h8000, ST_OK,
                  64'h0000_0002_0000_0001, 8'd0);
        add_check(OP_ALLOC, '0, 16'h0000, ST_INVALID, '0, 8'd0);
        add_check(OP_UNUSED, 64'h0000_0001_0000_0002, 16'h0001, ST_INVALID, '0, 8'd0);
        add_check(OP_RELEASE, 64'h0000_0001_0000_0002, 16'h0001, ST_OK, '0, 8'd1);
        add_cfg(1'b0);
        add_check(OP_ALLOC, '0, 16'h0007, ST_INVALID, '0, 8'd0);
        add_check(OP_LOOKUP, 64'h0000_0002_0000_0001, 16'h8000, ST_OK, '0, 8'd0);
        add_cfg(1'b1);
        add_item(OP_ALLOC, 64'h5555_5555_AAAA_AAAA, 16'h0007);
        add_item(OP_LOOKUP, 64'h0000_0002_0000_0002, 16'h0007);
        add_check(OP_RELEASE, 64'h0000_0002_0000_0001, 16'h8000, ST_OK, '0, 8'd0);

        // reset, then leave the clearing pass to the handshake
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < directed_plan.size(); r++) begin
            if (directed_plan[r].what == ROW_CFG) begin
                set_allocation_enable(directed_plan[r].enable);
            end else begin
                more = (r + 1 < directed_plan.size()) && directed_plan[r + 1].what == ROW_ITEM;
                send_request(directed_plan[r].op, directed_plan[r].handle, directed_plan[r].kind,
                             directed_plan[r].typed, directed_plan[r].want, more);
            end
        end

        // random phases: fill to full, refused allocation, drain, then a mix
        for (int p = 0; p < 4; p++) begin
            set_allocation_enable(ph_enable[p][0]);
            for (int j = 0; j < ph_count[p]; j++) begin
                make_item(ph_alloc[p], ph_access[p], op, h, k);
                send_request(op, h, k, 1'b0, none, j < ph_count[p] - 1);
            end
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
